[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/lts_pkg.sv]
package lts_pkg;

    localparam int WORD_W    = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 32;
    localparam int ROW_W     = 4;
    localparam int SIZE_W    = 5;
    localparam int STAT_W    = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RHS   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    localparam logic [WORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_MAG = 32'h8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIVGO,
        S_DIVWAIT
    } seq_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_ITER,
        D_DONE
    } div_state_t;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] value;
    } div_res_t;

endpackage

[design/lts_mat_ram.sv]
module lts_mat_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [lts_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [lts_pkg::WORD_W-1:0] rdata
);
    import lts_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/lts_divider.sv]
`include "assert_macros.svh"

module lts_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lts_pkg::ACC_W-1:0]  dividend,
    input  logic [lts_pkg::WORD_W-1:0] divisor,
    output lts_pkg::div_res_t          res
);
    import lts_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    div_state_t        state_reg, state_next;
    logic [ACC_W-1:0]  mag_reg;      // low half becomes the quotient
    logic [WORD_W-1:0] pmag_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic              ovf_reg;

    logic              hi_ge;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              step_ge;
    logic [WORD_W-1:0] quot;

    assign hi_ge   = mag_reg[ACC_W-1:WORD_W] >= pmag_reg;
    assign rem_sh  = {rem_reg, mag_reg[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, pmag_reg};
    assign step_ge = rem_sh >= {1'b0, pmag_reg};
    assign quot    = mag_reg[WORD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // zero divisor or quotient of 2^32 or more: no iterations
                state_next = (zero_reg || hi_ge) ? D_DONE : D_ITER;
            end
            D_ITER:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.done   = (state_reg == D_DONE);
        res.status = ST_OK;
        res.value  = '0;
        if (zero_reg)
        begin
            res.status = ST_ZERO;
        end
        else if (ovf_reg)
        begin
            res.status = ST_SAT;
            res.value  = neg_reg ? NEG_MAG : POS_MAX;
        end
        else if (neg_reg)
        begin
            if (quot > NEG_MAG)
            begin
                res.status = ST_SAT;
                res.value  = NEG_MAG;
            end
            else
            begin
                res.value = WORD_W'(0) - quot;
            end
        end
        else
        begin
            if (quot > POS_MAX)
            begin
                res.status = ST_SAT;
                res.value  = POS_MAX;
            end
            else
            begin
                res.value = quot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    mag_reg  <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
                    pmag_reg <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
                    neg_reg  <= dividend[ACC_W-1] ^ divisor[WORD_W-1];
                    zero_reg <= (divisor == '0);
                end
            end
            D_CHECK:
            begin
                ovf_reg <= hi_ge;
                rem_reg <= mag_reg[ACC_W-1:WORD_W];
                cnt_reg <= '0;
            end
            D_ITER:
            begin
                rem_reg <= step_ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                mag_reg[WORD_W-1:0] <= {mag_reg[WORD_W-2:0], step_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPL(a_rem_below_divisor, state_reg == D_ITER, rem_reg < pmag_reg)
    `ASSERT_NEXT(a_done_single, res.done, !res.done)
    `ASSERT_IMPL(a_start_when_idle, start, state_reg == D_IDLE)

endmodule

[design/lower_triangular_forward_solve_core.sv]
`include "assert_macros.svh"

// Forward substitution solver for L*y = b, signed Q16.16.
// Input transactions: start with action/entry_row/entry_col/entry_value, taken
// at a clock edge where start is high and busy is low. Action 0 writes one
// lower-triangle entry of L (upper entries and rows beyond MAX_SIZE are
// dropped) and busy stays low. Action 1 carries b for the
// next row i of the current column and produces exactly one result.
// Results: solution_value/solution_row/column_done/status shown for one cycle
// with result_valid high; the receiver cannot hold them off.
// For action 1 on row i, accept to strobe spans the multiply-accumulate walk
// over row i (one product per cycle out of the matrix RAM) and the radix-2
// divider (32 steps); a zero pivot or a quotient of 2^32 or more skips the
// steps. busy drops in the strobe cycle, so the next transaction may be
// taken there. Config: size_in_use is written with cfg_valid (cfg_ready is
// always high); the user must write it only while idle, the block does not
// enforce this. Reset clears the row counter and sets size_in_use to 16;
// the matrix and solution stores are not cleared and need no clearing pass.
module lower_triangular_forward_solve_core #(
    parameter int MAX_SIZE = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [lts_pkg::ROW_W-1:0]  entry_row,
    input  logic [lts_pkg::ROW_W-1:0]  entry_col,
    input  logic signed [lts_pkg::WORD_W-1:0] entry_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lts_pkg::SIZE_W-1:0] size_in_use,
    output logic                       result_valid,
    output logic signed [lts_pkg::WORD_W-1:0] solution_value,
    output logic [lts_pkg::ROW_W-1:0]  solution_row,
    output logic                       column_done,
    output logic [lts_pkg::STAT_W-1:0] status
);
    import lts_pkg::*;

    // rows reachable through a 4-bit row index
    localparam int LIM   = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int RW    = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int AW    = 2 * RW;
    localparam int DEPTH = 1 << AW;
    localparam logic [8:0]        MAX_W = 9'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] LIM_W = SIZE_W'(LIM);

    seq_state_t        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  i_reg;
    logic              last_reg;
    logic [ROW_W-1:0]  iss_idx_reg;
    logic              iss_on_reg;
    logic              p1_v_reg, p1_last_reg;
    logic              p2_v_reg;
    logic [WORD_W-1:0] y_rd_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [WORD_W-1:0] pivot_reg;
    logic [WORD_W-1:0] solved [LIM];

    logic              result_valid_reg;
    logic [WORD_W-1:0] sol_value_reg;
    logic [ROW_W-1:0]  sol_row_reg;
    logic              col_done_reg;
    logic [STAT_W-1:0] status_reg;

    logic              accept, accept_rhs, mat_we;
    logic              issue_en, div_start;
    logic [SIZE_W-1:0] n_eff;
    logic [ROW_W-1:0]  i_new;
    logic [WORD_W-1:0] ram_rdata;
    div_res_t          div_res;

    assign accept     = start && !busy;
    assign accept_rhs = accept && (action == ACT_RHS);
    assign mat_we     = accept && (action == ACT_WRITE) && (entry_col <= entry_row)
                        && ({5'b0, entry_row} < MAX_W);
    assign cfg_ready  = 1'b1;

    // rows in use: 0 acts as 1, anything above the store acts as its size
    always_comb
    begin
        n_eff = size_reg;
        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (size_reg > LIM_W)
        begin
            n_eff = LIM_W;
        end
    end

    assign i_new = ({1'b0, row_cnt_reg} >= n_eff) ? '0 : row_cnt_reg;

    lts_mat_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr ({entry_row[RW-1:0], entry_col[RW-1:0]}),
        .wdata (entry_value),
        .re    (issue_en),
        .raddr ({i_reg[RW-1:0], iss_idx_reg[RW-1:0]}),
        .rdata (ram_rdata)
    );

    lts_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (pivot_reg),
        .res      (div_res)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_rhs)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // pivot read back means the last product is accumulating now
                if (p1_v_reg && p1_last_reg)
                begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (div_res.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        issue_en  = (state_reg == S_MAC) && iss_on_reg;
        div_start = (state_reg == S_DIVGO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            size_reg         <= SIZE_W'(16);
            row_cnt_reg      <= '0;
            iss_on_reg       <= 1'b0;
            p1_v_reg         <= 1'b0;
            p2_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == S_DIVWAIT) && div_res.done;
            p1_v_reg         <= issue_en;
            p2_v_reg         <= p1_v_reg && !p1_last_reg;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= size_in_use;
            end
            if (accept_rhs)
            begin
                iss_on_reg <= 1'b1;
            end
            else if (issue_en && (iss_idx_reg == i_reg))
            begin
                iss_on_reg <= 1'b0;
            end
            if ((state_reg == S_DIVWAIT) && div_res.done)
            begin
                row_cnt_reg <= last_reg ? '0 : (i_reg + ROW_W'(1));
            end
        end
    end

    // datapath: products of row i against earlier solutions, one per cycle
    always_ff @(posedge clk)
    begin
        if (accept_rhs)
        begin
            i_reg       <= i_new;
            last_reg    <= ({1'b0, i_new} == (n_eff - SIZE_W'(1)));
            iss_idx_reg <= '0;
            acc_reg     <= {{(ACC_W - WORD_W - FRAC_BITS){entry_value[WORD_W-1]}},
                            entry_value, {FRAC_BITS{1'b0}}};
        end
        else
        begin
            if (p2_v_reg)
            begin
                acc_reg <= acc_reg - prod_reg;
            end
        end
        if (issue_en)
        begin
            iss_idx_reg <= iss_idx_reg + ROW_W'(1);
            p1_last_reg <= (iss_idx_reg == i_reg);
            y_rd_reg    <= solved[iss_idx_reg[RW-1:0]];
        end
        if (p1_v_reg)
        begin
            if (p1_last_reg)
            begin
                pivot_reg <= ram_rdata;
            end
            else
            begin
                prod_reg <= $signed(ram_rdata) * $signed(y_rd_reg);
            end
        end
        if ((state_reg == S_DIVWAIT) && div_res.done)
        begin
            solved[i_reg[RW-1:0]] <= div_res.value;
            sol_value_reg         <= div_res.value;
            sol_row_reg           <= i_reg;
            col_done_reg          <= last_reg;
            status_reg            <= div_res.status;
        end
    end

    assign result_valid   = result_valid_reg;
    assign solution_value = sol_value_reg;
    assign solution_row   = sol_row_reg;
    assign column_done    = col_done_reg;
    assign status         = status_reg;

    `ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
    `ASSERT_IMPL(a_strobe_when_idle, result_valid, state_reg == S_IDLE)
    `ASSERT_IMPL(a_column_wrap, result_valid && column_done, row_cnt_reg == '0)

endmodule
